// ===== rtl/core/qrs_pkg.sv =====
// shared types and constants for the quadratic root solver
// no dependencies
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int DEF_COEF_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int TOL_W          = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_COMPLEX = 2'd1,
        KIND_LINEAR  = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

endpackage

// ===== rtl/core/quadratic_root_solver.sv =====
// top level of the quadratic root solver: tolerance register, pipeline and output stage
// depends on qrs_pkg, qrs_front, qrs_sqrt, qrs_prep, qrs_div
//
//   channel | direction | transfer when             | payload
//   in      | input     | i_in_valid & o_in_ready   | i_coef_square, i_coef_linear, i_coef_constant
//   out     | output    | o_out_valid & i_out_ready | o_first_/o_second_ real and imag, kind, sat
//   cfg     | input     | i_cfg_valid & o_cfg_ready | i_cfg_near_zero_tolerance
//
// one item per cycle while the output register is empty or being taken
// the square root has COEF_WIDTH+1 stages and each divider lane has COEF_WIDTH stages
// every stage advances together whenever the output register is empty or being taken
// synchronous active-low reset clears all valid bits and loads a tolerance of 7
`timescale 1ns / 1ps

module quadratic_root_solver import qrs_pkg::*; #(
    parameter int COEF_WIDTH = DEF_COEF_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COEF_WIDTH-1:0] i_coef_square,
    input  logic signed [COEF_WIDTH-1:0] i_coef_linear,
    input  logic signed [COEF_WIDTH-1:0] i_coef_constant,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COEF_WIDTH-1:0] o_first_real,
    output logic signed [COEF_WIDTH-1:0] o_first_imag,
    output logic signed [COEF_WIDTH-1:0] o_second_real,
    output logic signed [COEF_WIDTH-1:0] o_second_imag,
    output logic [1:0]                   o_root_kind,
    output logic                         o_saturated,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [TOL_W-1:0]             i_cfg_near_zero_tolerance
);

    localparam int W = COEF_WIDTH;

    typedef struct packed {
        t_kind        kind;
        logic         na;
        logic         nb;
        logic         nc;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] mc;
    } t_sq_ctx;

    typedef struct packed {
        t_kind kind;
        logic  neg;
    } t_dv_ctx;

    localparam int SQ_W = $bits(t_sq_ctx);
    localparam int DV_W = $bits(t_dv_ctx);

    logic             en;
    logic [TOL_W-1:0] r_tol;

    logic           f_valid, f_na, f_nb, f_nc;
    t_kind          f_kind;
    logic [W-1:0]   f_ma, f_mb, f_mc;
    logic [2*W:0]   f_disc;

    t_sq_ctx        sq_in, sq_out;
    logic           s_valid;
    logic [W:0]     s_root;

    logic           p_valid, p_ovf0, p_ovf1, p_neg0, p_neg1;
    t_kind          p_kind;
    logic [W:0]     p_den, p_rem0, p_rem1;
    logic [W-1:0]   p_low0, p_low1;

    t_dv_ctx        d0_in, d0_out;
    logic           w_v0, w_v1, d_ovf0, d_ovf1, d1_neg;
    logic [W-1:0]   d_q0, d_q1;

    logic [W:0]     e0, e1, e2;
    logic [W-1:0]   n_fr, n_fi, n_sr, n_si;
    logic           n_sat;

    logic           r_out_valid, r_sat;
    logic [W-1:0]   r_fr, r_fi, r_sr, r_si;
    t_kind          r_kind;

    // returns {clamped, value}
    function automatic logic [W:0] f_emit(input logic [W-1:0] q, input logic ovf,
                                          input logic neg);
        logic [W-1:0] lim, m;
        logic         clamp;
        lim   = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        clamp = ovf || (q > lim);
        m     = clamp ? lim : q;
        return {clamp, neg ? (~m + 1'b1) : m};
    endfunction

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_near_zero_tolerance;
        end
    end

    qrs_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_a     (i_coef_square),
        .i_b     (i_coef_linear),
        .i_c     (i_coef_constant),
        .i_tol   (r_tol),
        .o_valid (f_valid),
        .o_kind  (f_kind),
        .o_na    (f_na),
        .o_nb    (f_nb),
        .o_nc    (f_nc),
        .o_ma    (f_ma),
        .o_mb    (f_mb),
        .o_mc    (f_mc),
        .o_disc  (f_disc)
    );

    always_comb begin
        sq_in.kind = f_kind;
        sq_in.na   = f_na;
        sq_in.nb   = f_nb;
        sq_in.nc   = f_nc;
        sq_in.ma   = f_ma;
        sq_in.mb   = f_mb;
        sq_in.mc   = f_mc;
    end

    qrs_sqrt #(.W(W), .CTX_W(SQ_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_rad   (f_disc),
        .i_ctx   (sq_in),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_ctx   (sq_out)
    );

    qrs_prep #(.W(W), .F(FRAC_BITS)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_kind  (sq_out.kind),
        .i_na    (sq_out.na),
        .i_nb    (sq_out.nb),
        .i_nc    (sq_out.nc),
        .i_ma    (sq_out.ma),
        .i_mb    (sq_out.mb),
        .i_mc    (sq_out.mc),
        .i_root  (s_root),
        .o_valid (p_valid),
        .o_kind  (p_kind),
        .o_den   (p_den),
        .o_rem0  (p_rem0),
        .o_low0  (p_low0),
        .o_ovf0  (p_ovf0),
        .o_neg0  (p_neg0),
        .o_rem1  (p_rem1),
        .o_low1  (p_low1),
        .o_ovf1  (p_ovf1),
        .o_neg1  (p_neg1)
    );

    always_comb begin
        d0_in.kind = p_kind;
        d0_in.neg  = p_neg0;
    end

    qrs_div #(.W(W), .CTX_W(DV_W)) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_rem   (p_rem0),
        .i_low   (p_low0),
        .i_den   (p_den),
        .i_ovf   (p_ovf0),
        .i_ctx   (d0_in),
        .o_valid (w_v0),
        .o_quot  (d_q0),
        .o_ovf   (d_ovf0),
        .o_ctx   (d0_out)
    );

    qrs_div #(.W(W), .CTX_W(1)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_rem   (p_rem1),
        .i_low   (p_low1),
        .i_den   (p_den),
        .i_ovf   (p_ovf1),
        .i_ctx   (p_neg1),
        .o_valid (w_v1),
        .o_quot  (d_q1),
        .o_ovf   (d_ovf1),
        .o_ctx   (d1_neg)
    );

    // clamp, apply signs and place the root parts by kind
    always_comb begin
        e0 = f_emit(d_q0, d_ovf0, d0_out.neg);
        e1 = f_emit(d_q1, d_ovf1, d1_neg);
        e2 = f_emit(d_q1, d_ovf1, !d1_neg);
        unique case (d0_out.kind)
            KIND_REAL: begin
                n_fr  = e0[W-1:0];
                n_fi  = '0;
                n_sr  = e1[W-1:0];
                n_si  = '0;
                n_sat = e0[W] | e1[W];
            end
            KIND_COMPLEX: begin
                n_fr  = e0[W-1:0];
                n_fi  = e1[W-1:0];
                n_sr  = e0[W-1:0];
                n_si  = e2[W-1:0];
                n_sat = e0[W] | e1[W] | e2[W];
            end
            KIND_LINEAR: begin
                n_fr  = e0[W-1:0];
                n_fi  = '0;
                n_sr  = e0[W-1:0];
                n_si  = '0;
                n_sat = e0[W];
            end
            KIND_NONE: begin
                n_fr  = '0;
                n_fi  = '0;
                n_sr  = '0;
                n_si  = '0;
                n_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fr   <= n_fr;
            r_fi   <= n_fi;
            r_sr   <= n_sr;
            r_si   <= n_si;
            r_sat  <= n_sat;
            r_kind <= d0_out.kind;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_first_real  = r_fr;
    assign o_first_imag  = r_fi;
    assign o_second_real = r_sr;
    assign o_second_imag = r_si;
    assign o_root_kind   = r_kind;
    assign o_saturated   = r_sat;

`ifndef SYNTHESIS
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v0 == w_v1)
        else $error("divider lanes out of step");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_root_kind == KIND_NONE |->
            !o_saturated && o_first_real == '0 && o_second_real == '0)
        else $error("no-solution result not cleared");

    a_real_imag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_root_kind != KIND_COMPLEX |->
            o_first_imag == '0 && o_second_imag == '0)
        else $error("imaginary part on a real result");

    a_linear_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_root_kind == KIND_LINEAR |-> o_first_real == o_second_real)
        else $error("linear roots differ");

    a_conjugate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_root_kind == KIND_COMPLEX && !o_saturated |->
            o_second_imag == -o_first_imag && o_first_real == o_second_real)
        else $error("complex roots not conjugate");
`endif

endmodule

// ===== rtl/core/qrs_front.sv =====
// front end: coefficient split, products and exact discriminant (three stages)
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_front import qrs_pkg::*; #(
    parameter int W = DEF_COEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    input  logic [W-1:0]     i_c,
    input  logic [TOL_W-1:0] i_tol,
    output logic             o_valid,
    output t_kind            o_kind,
    output logic             o_na,
    output logic             o_nb,
    output logic             o_nc,
    output logic [W-1:0]     o_ma,
    output logic [W-1:0]     o_mb,
    output logic [W-1:0]     o_mc,
    output logic [2*W:0]     o_disc
);

    logic [W-1:0] n_ma, n_mb, n_mc, tol_x;
    logic         n_as, n_bs;

    logic           r_va, r_na, r_nb, r_nc, r_as, r_bs;
    logic [W-1:0]   r_ma, r_mb, r_mc;

    logic           r_vb, r_na2, r_nb2, r_nc2, r_as2, r_bs2;
    logic [W-1:0]   r_ma2, r_mb2, r_mc2;
    logic [2*W-1:0] r_bb, r_ac;

    logic [2*W+1:0] b2_x, ac4_x, n_d;
    logic           n_dneg;
    t_kind          n_kind;

    logic           r_vc, r_na3, r_nb3, r_nc3;
    logic [W-1:0]   r_ma3, r_mb3, r_mc3;
    logic [2*W:0]   r_disc;
    t_kind          r_kind;

    // sign and magnitude, the most negative code gives a magnitude of 2^(W-1)
    always_comb begin
        tol_x = W'(i_tol);
        n_ma  = i_a[W-1] ? (~i_a + 1'b1) : i_a;
        n_mb  = i_b[W-1] ? (~i_b + 1'b1) : i_b;
        n_mc  = i_c[W-1] ? (~i_c + 1'b1) : i_c;
        n_as  = (n_ma < tol_x) || (n_ma == '0);
        n_bs  = (n_mb < tol_x) || (n_mb == '0);
    end

    // discriminant in sign and magnitude
    always_comb begin
        b2_x  = {2'b00, r_bb};
        ac4_x = {r_ac, 2'b00};
        if (r_na2 != r_nc2) begin
            n_d    = b2_x + ac4_x;
            n_dneg = 1'b0;
        end else if (b2_x >= ac4_x) begin
            n_d    = b2_x - ac4_x;
            n_dneg = 1'b0;
        end else begin
            n_d    = ac4_x - b2_x;
            n_dneg = 1'b1;
        end
        if (r_as2) begin
            n_kind = r_bs2 ? KIND_NONE : KIND_LINEAR;
        end else begin
            n_kind = n_dneg ? KIND_COMPLEX : KIND_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_na  <= i_a[W-1];
            r_nb  <= i_b[W-1];
            r_nc  <= i_c[W-1];
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_mc  <= n_mc;
            r_as  <= n_as;
            r_bs  <= n_bs;

            r_na2 <= r_na;
            r_nb2 <= r_nb;
            r_nc2 <= r_nc;
            r_ma2 <= r_ma;
            r_mb2 <= r_mb;
            r_mc2 <= r_mc;
            r_as2 <= r_as;
            r_bs2 <= r_bs;
            r_bb  <= r_mb * r_mb;
            r_ac  <= r_ma * r_mc;

            r_na3  <= r_na2;
            r_nb3  <= r_nb2;
            r_nc3  <= r_nc2;
            r_ma3  <= r_ma2;
            r_mb3  <= r_mb2;
            r_mc3  <= r_mc2;
            r_disc <= n_d[2*W:0];
            r_kind <= n_kind;
        end
    end

    assign o_valid = r_vc;
    assign o_kind  = r_kind;
    assign o_na    = r_na3;
    assign o_nb    = r_nb3;
    assign o_nc    = r_nc3;
    assign o_ma    = r_ma3;
    assign o_mb    = r_mb3;
    assign o_mc    = r_mc3;
    assign o_disc  = r_disc;

endmodule

// ===== rtl/core/qrs_sqrt.sv =====
// pipelined floor square root, one root bit per stage, context carried alongside
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_sqrt import qrs_pkg::*; #(
    parameter int W     = DEF_COEF_WIDTH,
    parameter int CTX_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [2*W:0]     i_rad,
    input  logic [CTX_W-1:0] i_ctx,
    output logic             o_valid,
    output logic [W:0]       o_root,
    output logic [CTX_W-1:0] o_ctx
);

    localparam int R  = W + 1;
    localparam int RW = R + 2;
    localparam int TW = RW + 2;

    logic             r_v    [R];
    logic [RW-1:0]    r_rem  [R];
    logic [R-1:0]     r_root [R];
    logic [2*R-1:0]   r_rest [R];
    logic [CTX_W-1:0] r_ctx  [R];

    for (genvar k = 0; k < R; k++) begin : g_stage
        logic             p_v;
        logic [RW-1:0]    p_rem;
        logic [R-1:0]     p_root;
        logic [2*R-1:0]   p_rest;
        logic [CTX_W-1:0] p_ctx;
        logic [TW-1:0]    trial, cmp;
        logic             ge;
        logic [RW-1:0]    n_rem;
        logic [R-1:0]     n_root;
        logic [2*R-1:0]   n_rest;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rest = {1'b0, i_rad};
            assign p_ctx  = i_ctx;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rest = r_rest[k-1];
            assign p_ctx  = r_ctx[k-1];
        end

        always_comb begin
            trial  = {p_rem, p_rest[2*R-1 -: 2]};
            cmp    = TW'({p_root, 2'b01});
            ge     = trial >= cmp;
            n_rem  = ge ? RW'(trial - cmp) : RW'(trial);
            n_root = {p_root[R-2:0], ge};
            n_rest = {p_rest[2*R-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rest[k] <= n_rest;
                r_ctx[k]  <= p_ctx;
            end
        end
    end

    assign o_valid = r_v[R-1];
    assign o_root  = r_root[R-1];
    assign o_ctx   = r_ctx[R-1];

endmodule

// ===== rtl/core/qrs_prep.sv =====
// numerators, divisor and quotient overflow test for both divider lanes (two stages)
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_prep import qrs_pkg::*; #(
    parameter int W = DEF_COEF_WIDTH,
    parameter int F = DEF_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  t_kind        i_kind,
    input  logic         i_na,
    input  logic         i_nb,
    input  logic         i_nc,
    input  logic [W-1:0] i_ma,
    input  logic [W-1:0] i_mb,
    input  logic [W-1:0] i_mc,
    input  logic [W:0]   i_root,
    output logic         o_valid,
    output t_kind        o_kind,
    output logic [W:0]   o_den,
    output logic [W:0]   o_rem0,
    output logic [W-1:0] o_low0,
    output logic         o_ovf0,
    output logic         o_neg0,
    output logic [W:0]   o_rem1,
    output logic [W-1:0] o_low1,
    output logic         o_ovf1,
    output logic         o_neg1
);

    localparam int NW  = W + 2;
    localparam int DW  = W + 1;
    localparam int NSW = NW + F;

    logic [NW-1:0] mb_x, mc_x, rad_x, sum, dif_br, dif_rb, t, u;
    logic          b_ge, rn0, rn1;
    logic [NW-1:0] n_num0, n_num1;
    logic [DW-1:0] n_den;
    logic          n_neg0, n_neg1;

    logic          r_v1, r_neg0_1, r_neg1_1;
    t_kind         r_kind1;
    logic [NW-1:0] r_num0, r_num1;
    logic [DW-1:0] r_den1;

    logic [NSW-1:0] sc0, sc1, hi0, hi1, den_x;

    logic          r_v2, r_neg0, r_neg1, r_ovf0, r_ovf1;
    t_kind         r_kind2;
    logic [DW-1:0] r_den2, r_rem0, r_rem1;
    logic [W-1:0]  r_low0, r_low1;

    // -b plus and minus the root, in sign and magnitude
    always_comb begin
        mb_x   = NW'(i_mb);
        mc_x   = NW'(i_mc);
        rad_x  = NW'(i_root);
        b_ge   = mb_x >= rad_x;
        sum    = mb_x + rad_x;
        dif_br = mb_x - rad_x;
        dif_rb = rad_x - mb_x;
        if (i_nb) begin
            t   = sum;
            rn0 = 1'b0;
            u   = b_ge ? dif_br : dif_rb;
            rn1 = !b_ge;
        end else begin
            t   = b_ge ? dif_br : dif_rb;
            rn0 = b_ge;
            u   = sum;
            rn1 = 1'b1;
        end
    end

    always_comb begin
        unique case (i_kind)
            KIND_REAL: begin
                n_num0 = t;
                n_num1 = u;
                n_den  = {i_ma, 1'b0};
                n_neg0 = rn0 ^ i_na;
                n_neg1 = rn1 ^ i_na;
            end
            KIND_COMPLEX: begin
                n_num0 = mb_x;
                n_num1 = rad_x;
                n_den  = {i_ma, 1'b0};
                n_neg0 = !i_nb ^ i_na;
                n_neg1 = i_na;
            end
            KIND_LINEAR: begin
                n_num0 = mc_x;
                n_num1 = '0;
                n_den  = DW'(i_mb);
                n_neg0 = !i_nc ^ i_nb;
                n_neg1 = 1'b0;
            end
            KIND_NONE: begin
                n_num0 = '0;
                n_num1 = '0;
                n_den  = DW'(1);
                n_neg0 = 1'b0;
                n_neg1 = 1'b0;
            end
        endcase
    end

    // quotient reaches 2^W exactly when the top of the scaled dividend reaches the divisor
    always_comb begin
        sc0   = {r_num0, {F{1'b0}}};
        sc1   = {r_num1, {F{1'b0}}};
        hi0   = sc0 >> W;
        hi1   = sc1 >> W;
        den_x = NSW'(r_den1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind1  <= i_kind;
            r_num0   <= n_num0;
            r_num1   <= n_num1;
            r_den1   <= n_den;
            r_neg0_1 <= n_neg0;
            r_neg1_1 <= n_neg1;

            r_kind2 <= r_kind1;
            r_den2  <= r_den1;
            r_neg0  <= r_neg0_1;
            r_neg1  <= r_neg1_1;
            r_ovf0  <= hi0 >= den_x;
            r_ovf1  <= hi1 >= den_x;
            r_rem0  <= hi0[DW-1:0];
            r_rem1  <= hi1[DW-1:0];
            r_low0  <= sc0[W-1:0];
            r_low1  <= sc1[W-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_kind  = r_kind2;
    assign o_den   = r_den2;
    assign o_rem0  = r_rem0;
    assign o_low0  = r_low0;
    assign o_ovf0  = r_ovf0;
    assign o_neg0  = r_neg0;
    assign o_rem1  = r_rem1;
    assign o_low1  = r_low1;
    assign o_ovf1  = r_ovf1;
    assign o_neg1  = r_neg1;

endmodule

// ===== rtl/core/qrs_div.sv =====
// pipelined restoring divider lane, one quotient bit per stage
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_div import qrs_pkg::*; #(
    parameter int W     = DEF_COEF_WIDTH,
    parameter int CTX_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [W:0]       i_rem,
    input  logic [W-1:0]     i_low,
    input  logic [W:0]       i_den,
    input  logic             i_ovf,
    input  logic [CTX_W-1:0] i_ctx,
    output logic             o_valid,
    output logic [W-1:0]     o_quot,
    output logic             o_ovf,
    output logic [CTX_W-1:0] o_ctx
);

    localparam int DW = W + 1;
    localparam int TW = W + 2;

    logic             r_v    [W];
    logic [DW-1:0]    r_rem  [W];
    logic [W-1:0]     r_low  [W];
    logic [W-1:0]     r_quot [W];
    logic [DW-1:0]    r_den  [W];
    logic             r_ovf  [W];
    logic [CTX_W-1:0] r_ctx  [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic             p_v, p_ovf;
        logic [DW-1:0]    p_rem, p_den;
        logic [W-1:0]     p_low, p_quot;
        logic [CTX_W-1:0] p_ctx;
        logic [TW-1:0]    trial, den_x;
        logic             ge;
        logic [DW-1:0]    n_rem;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = i_rem;
            assign p_low  = i_low;
            assign p_quot = '0;
            assign p_den  = i_den;
            assign p_ovf  = i_ovf;
            assign p_ctx  = i_ctx;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_low  = r_low[k-1];
            assign p_quot = r_quot[k-1];
            assign p_den  = r_den[k-1];
            assign p_ovf  = r_ovf[k-1];
            assign p_ctx  = r_ctx[k-1];
        end

        always_comb begin
            trial = {p_rem, p_low[W-1]};
            den_x = TW'(p_den);
            ge    = trial >= den_x;
            n_rem = ge ? DW'(trial - den_x) : DW'(trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= {p_low[W-2:0], 1'b0};
                r_quot[k] <= {p_quot[W-2:0], ge};
                r_den[k]  <= p_den;
                r_ovf[k]  <= p_ovf;
                r_ctx[k]  <= p_ctx;
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quot  = r_quot[W-1];
    assign o_ovf   = r_ovf[W-1];
    assign o_ctx   = r_ctx[W-1];

endmodule
